@@ rtl/rfs_pkg.sv @@
// ----------------------------------------------------------------------------
// rfs_pkg
// Shared constants and types for the river flow sampler.
// ----------------------------------------------------------------------------
package rfs_pkg;

  localparam int MaxNodes = 64;
  localparam int NodeAw   = $clog2(MaxNodes);
  localparam int IdxW     = NodeAw + 1;

  localparam logic [16:0] OneQ16   = 17'h10000;
  localparam logic [16:0] ProfBase = 17'd36045;
  localparam logic [16:0] ProfSpan = 17'd29491;

  // register indexes on the configuration channel
  localparam logic [2:0] RegBoxMinX  = 3'd0;
  localparam logic [2:0] RegBoxMaxX  = 3'd1;
  localparam logic [2:0] RegBoxMinZ  = 3'd2;
  localparam logic [2:0] RegBoxMaxZ  = 3'd3;
  localparam logic [2:0] RegSpeed    = 3'd4;
  localparam logic [2:0] RegNodeCnt  = 3'd5;

  localparam int NodeW = 95;

  typedef struct packed {
    logic signed [23:0] level;
    logic        [22:0] half;
    logic signed [23:0] z;
    logic signed [23:0] x;
  } node_t;

  typedef struct packed {
    logic signed [23:0] box_min_x;
    logic signed [23:0] box_max_x;
    logic signed [23:0] box_min_z;
    logic signed [23:0] box_max_z;
    logic        [15:0] flow_speed;
    logic        [6:0]  node_count;
  } cfg_t;

  typedef struct packed {
    logic signed [23:0] surface_out;
    logic        [16:0] weight;
    logic signed [16:0] flow_z;
    logic signed [16:0] flow_x;
  } res_t;

endpackage

@@ rtl/river_flow_sample.sv @@
// ----------------------------------------------------------------------------
// river_flow_sample
// River centre-line store and flow/weight/surface sampler.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser[0] is the command (0 writes a node, 1 queries).
//   A node write produces no result transaction.
//   A query produces exactly one result transaction on the master stream;
//   points outside the box, or with no segment hit, return all zeros.
//   A query walks the segments in turn; the t divide is skipped when t
//   clamps to 0 or 1, a zero-length segment is skipped, and only a
//   segment that becomes the new best hit runs the unit-vector, profile
//   and surface steps. The sequencer uses one shared multiplier, an
//   iterative divider with 16 fraction bits and a 28-step square root.
//   One item is worked on at a time; tready is high while the sequencer
//   is idle, also while a finished result still waits in the output
//   register. A stalled master side holds the result and stops the next
//   query only at its end.
//   Configuration: write cfg_index_i / cfg_data_i, always ready; only
//   while idle. Reset clears the configuration and control; node RAM is not
//   cleared and must be written before it is queried.
// ----------------------------------------------------------------------------
module river_flow_sample import rfs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // node_index[5:0], pos_x[29:6], pos_z[53:30], half_width[76:54],
  // surface_level[100:77]
  input  logic [103:0] s_axis_tdata,
  // cmd[0]
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // flow_x[16:0], flow_z[33:17], weight[50:34], surface_out[74:51]
  output logic [79:0]  m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [23:0]  cfg_data_i
);

  cfg_t              cfg_q;
  logic              m_valid_q;
  res_t              m_data_q;
  logic              accept;
  logic              is_query;
  logic              eng_idle;
  logic              res_valid;
  res_t              res;
  logic              rd_en;
  logic [NodeAw-1:0] rd_addr;
  logic [NodeW-1:0]  rd_raw;
  node_t             wr_node;
  logic              wr_en;
  logic              out_free;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign is_query = s_axis_tuser[0];
  assign out_free = !m_valid_q || m_axis_tready;

  assign wr_node.x     = s_axis_tdata[29:6];
  assign wr_node.z     = s_axis_tdata[53:30];
  assign wr_node.half  = s_axis_tdata[76:54];
  assign wr_node.level = s_axis_tdata[100:77];
  assign wr_en = accept && !is_query && (int'(s_axis_tdata[5:0]) < MaxNodes);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegBoxMinX: cfg_q.box_min_x  <= cfg_data_i;
        RegBoxMaxX: cfg_q.box_max_x  <= cfg_data_i;
        RegBoxMinZ: cfg_q.box_min_z  <= cfg_data_i;
        RegBoxMaxZ: cfg_q.box_max_z  <= cfg_data_i;
        RegSpeed:   cfg_q.flow_speed <= cfg_data_i[15:0];
        RegNodeCnt: cfg_q.node_count <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  rfs_ram #(
    .Width (NodeW),
    .Depth (MaxNodes)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (NodeAw'(s_axis_tdata[5:0])),
    .wdata_i (wr_node),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_raw)
  );

  rfs_eng u_eng (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept && is_query),
    .px_i        (s_axis_tdata[29:6]),
    .pz_i        (s_axis_tdata[53:30]),
    .cfg_i       (cfg_q),
    .out_free_i  (out_free),
    .idle_o      (eng_idle),
    .res_valid_o (res_valid),
    .res_o       (res),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (node_t'(rd_raw))
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_valid) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      m_data_q <= res;
    end
  end

  assign s_axis_tready = eng_idle;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'd0, m_data_q};

endmodule

@@ rtl/rfs_ram.sv @@
// ----------------------------------------------------------------------------
// rfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rfs_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/rfs_div.sv @@
// ----------------------------------------------------------------------------
// rfs_div
// Restoring divider: quo = floor(num * 2^16 / den), for num <= den.
// ----------------------------------------------------------------------------
module rfs_div import rfs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [51:0] num_i,
  input  logic [51:0] den_i,
  output logic        done_o,
  output logic [16:0] quo_o
);

  logic [52:0] rem_q;
  logic [51:0] den_q;
  logic [16:0] quo_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [52:0] rem_sh;
  logic        ge;
  logic        ge0;

  assign rem_sh = {rem_q[51:0], 1'b0};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign ge0    = num_i >= den_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd16;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // integer bit is settled at start, then one fraction bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= ge0 ? {1'b0, num_i - den_i} : {1'b0, num_i};
      quo_q <= {16'd0, ge0};
    end else if (busy_q) begin
      rem_q <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
      quo_q <= {quo_q[15:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

@@ rtl/rfs_sqrt.sv @@
// ----------------------------------------------------------------------------
// rfs_sqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module rfs_sqrt import rfs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [55:0] op_i,
  output logic        done_o,
  output logic [27:0] root_o
);

  logic [55:0] v_q;
  logic [55:0] res_q;
  logic [55:0] bit_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [55:0] trial;

  assign trial = res_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd28;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= op_i;
      res_q <= '0;
      bit_q <= 56'd1 << 54;
    end else if (busy_q) begin
      if (v_q >= trial) begin
        v_q   <= v_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[27:0];

endmodule

@@ rtl/rfs_eng.sv @@
// ----------------------------------------------------------------------------
// rfs_eng
// Query sequencer: walks the node RAM segment by segment, one shared
// multiplier plus iterative divider and square root, keeps the best hit.
// ----------------------------------------------------------------------------
module rfs_eng import rfs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [23:0] px_i,
  input  logic signed [23:0] pz_i,
  input  cfg_t               cfg_i,
  input  logic               out_free_i,
  output logic               idle_o,
  output logic               res_valid_o,
  output res_t               res_o,
  output logic               rd_en_o,
  output logic [NodeAw-1:0]  rd_addr_o,
  input  node_t              rd_data_i
);

  localparam logic [5:0] SIdle = 6'd0;
  localparam logic [5:0] SRdA  = 6'd1;
  localparam logic [5:0] SLdA  = 6'd2;
  localparam logic [5:0] SRdB  = 6'd3;
  localparam logic [5:0] SLdB  = 6'd4;
  localparam logic [5:0] SL2A  = 6'd5;
  localparam logic [5:0] SL2B  = 6'd6;
  localparam logic [5:0] SL2C  = 6'd7;
  localparam logic [5:0] SDtA  = 6'd8;
  localparam logic [5:0] SDtB  = 6'd9;
  localparam logic [5:0] STSel = 6'd10;
  localparam logic [5:0] STDiv = 6'd11;
  localparam logic [5:0] SDxA  = 6'd12;
  localparam logic [5:0] SDxB  = 6'd13;
  localparam logic [5:0] SDzB  = 6'd14;
  localparam logic [5:0] SDdA  = 6'd15;
  localparam logic [5:0] SDdB  = 6'd16;
  localparam logic [5:0] SDdC  = 6'd17;
  localparam logic [5:0] SDSq  = 6'd18;
  localparam logic [5:0] SHA   = 6'd19;
  localparam logic [5:0] SHB   = 6'd20;
  localparam logic [5:0] SHC   = 6'd21;
  localparam logic [5:0] SHChk = 6'd22;
  localparam logic [5:0] SLDiv = 6'd23;
  localparam logic [5:0] SLCmp = 6'd24;
  localparam logic [5:0] SLSq  = 6'd25;
  localparam logic [5:0] SUxS  = 6'd26;
  localparam logic [5:0] SUxW  = 6'd27;
  localparam logic [5:0] SUzS  = 6'd28;
  localparam logic [5:0] SUzW  = 6'd29;
  localparam logic [5:0] SPA   = 6'd30;
  localparam logic [5:0] SPB   = 6'd31;
  localparam logic [5:0] SPC   = 6'd32;
  localparam logic [5:0] SPD   = 6'd33;
  localparam logic [5:0] SFxA  = 6'd34;
  localparam logic [5:0] SFxB  = 6'd35;
  localparam logic [5:0] SFxC  = 6'd36;
  localparam logic [5:0] SFzB  = 6'd37;
  localparam logic [5:0] SFzC  = 6'd38;
  localparam logic [5:0] SSA   = 6'd39;
  localparam logic [5:0] SSB   = 6'd40;
  localparam logic [5:0] SSC   = 6'd41;
  localparam logic [5:0] SNext = 6'd42;
  localparam logic [5:0] SDone = 6'd43;

  logic [5:0]         state_q, state_d;
  logic [IdxW-1:0]    idx_q;
  logic [IdxW-1:0]    n_q;
  logic [IdxW-1:0]    n_calc;

  logic signed [23:0] px_q, pz_q;
  node_t              a_q, b_q;
  logic signed [24:0] abx_q, abz_q, qx_q, qz_q;
  logic [51:0]        len2_q;
  logic signed [51:0] dot_q;
  logic [16:0]        t_q;
  logic signed [27:0] dx_q, dz_q;
  logic [55:0]        sq_acc_q;
  logic [27:0]        dist_q;
  logic signed [63:0] part_q;
  logic [23:0]        half_q;
  logic [16:0]        lat_q;
  logic [27:0]        len_q;
  logic signed [17:0] ux_q, uz_q;
  logic [16:0]        lat2_q;
  logic [16:0]        prof_q;
  logic signed [16:0] fx_q, fz_q;
  logic [16:0]        best_lat_q, best_w_q;
  logic signed [16:0] best_fx_q, best_fz_q;
  logic signed [23:0] best_surf_q;
  logic signed [63:0] prod_q;

  logic signed [35:0] mul_a;
  logic signed [27:0] mul_b;
  logic [16:0]        t_inv;
  logic               in_box;

  logic        div_start, div_done;
  logic [51:0] div_num, div_den;
  logic [16:0] div_quo;
  logic        sq_start, sq_done;
  logic [55:0] sq_op;
  logic [27:0] sq_root;

  logic signed [63:0] dx_full, dz_full, half_full, surf_full, lat2_full, prof_full;
  logic signed [63:0] flow_full;
  logic signed [31:0] flow_r;
  logic signed [16:0] flow_c;
  logic               t_mid, seg_ok, seg_better;
  logic [24:0]        abx_mag, abz_mag;

  assign t_inv  = OneQ16 - t_q;
  assign in_box = !(px_i < cfg_i.box_min_x || px_i > cfg_i.box_max_x ||
                    pz_i < cfg_i.box_min_z || pz_i > cfg_i.box_max_z);
  assign n_calc = (int'(cfg_i.node_count) > MaxNodes) ? IdxW'(MaxNodes)
                                                      : IdxW'(cfg_i.node_count);

  assign t_mid      = (dot_q > 52'sd0) && ($unsigned(dot_q) < len2_q);
  assign seg_ok     = (half_q != 24'd0) && (dist_q <= {4'd0, half_q});
  assign seg_better = (best_w_q == 17'd0) || (lat_q < best_lat_q);
  assign abx_mag    = abx_q[24] ? 25'(-abx_q) : 25'(abx_q);
  assign abz_mag    = abz_q[24] ? 25'(-abz_q) : 25'(abz_q);

  // rounding: add half an lsb, then floor by arithmetic shift
  assign dx_full   = (64'(qx_q) <<< 16) - prod_q + 64'sd32768;
  assign dz_full   = (64'(qz_q) <<< 16) - prod_q + 64'sd32768;
  assign half_full = part_q + prod_q + 64'sd32768;
  assign surf_full = part_q + prod_q + 64'sd32768;
  assign lat2_full = prod_q + 64'sd32768;
  assign prof_full = prod_q + 64'sd32768;
  assign flow_full = prod_q + 64'sd2147483648;
  assign flow_r    = flow_full[63:32];
  assign flow_c    = (flow_r > 32'sd65535)  ? 17'sd65535 :
                     (flow_r < -32'sd65535) ? -17'sd65535 : flow_r[16:0];

  // shared multiplier, operands chosen by the step in progress
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      SL2A:  begin mul_a = 36'(abx_q); mul_b = 28'(abx_q); end
      SL2B:  begin mul_a = 36'(abz_q); mul_b = 28'(abz_q); end
      SL2C:  begin mul_a = 36'(qx_q);  mul_b = 28'(abx_q); end
      SDtA:  begin mul_a = 36'(qz_q);  mul_b = 28'(abz_q); end
      SDxA:  begin mul_a = 36'(abx_q); mul_b = $signed({11'd0, t_q}); end
      SDxB:  begin mul_a = 36'(abz_q); mul_b = $signed({11'd0, t_q}); end
      SDdA:  begin mul_a = 36'(dx_q);  mul_b = dx_q; end
      SDdB:  begin mul_a = 36'(dz_q);  mul_b = dz_q; end
      SHA:   begin mul_a = $signed({13'd0, a_q.half}); mul_b = $signed({11'd0, t_inv}); end
      SHB:   begin mul_a = $signed({13'd0, b_q.half}); mul_b = $signed({11'd0, t_q}); end
      SPA:   begin mul_a = $signed({19'd0, lat_q}); mul_b = $signed({11'd0, lat_q}); end
      SPC:   begin
        mul_a = $signed({19'd0, ProfSpan});
        mul_b = $signed({11'd0, OneQ16 - lat2_q});
      end
      SFxA:  begin mul_a = 36'(ux_q); mul_b = $signed({12'd0, cfg_i.flow_speed}); end
      SFxB:  begin mul_a = prod_q[35:0]; mul_b = $signed({11'd0, prof_q}); end
      SFxC:  begin mul_a = 36'(uz_q); mul_b = $signed({12'd0, cfg_i.flow_speed}); end
      SFzB:  begin mul_a = prod_q[35:0]; mul_b = $signed({11'd0, prof_q}); end
      SSA:   begin mul_a = 36'(a_q.level); mul_b = $signed({11'd0, t_inv}); end
      SSB:   begin mul_a = 36'(b_q.level); mul_b = $signed({11'd0, t_q}); end
      default: ;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state_q)
      STSel: begin
        div_start = t_mid;
        div_num   = $unsigned(dot_q);
        div_den   = len2_q;
      end
      SHChk: begin
        div_start = seg_ok;
        div_num   = 52'(dist_q);
        div_den   = 52'(half_q);
      end
      SUxS: begin
        div_start = 1'b1;
        div_num   = 52'(abx_mag);
        div_den   = 52'(len_q);
      end
      SUzS: begin
        div_start = 1'b1;
        div_num   = 52'(abz_mag);
        div_den   = 52'(len_q);
      end
      default: ;
    endcase
  end

  always_comb begin
    sq_start = 1'b0;
    sq_op    = '0;
    unique case (state_q)
      SDdC: begin
        sq_start = 1'b1;
        sq_op    = sq_acc_q + prod_q[55:0];
      end
      SLCmp: begin
        sq_start = seg_better;
        sq_op    = 56'(len2_q);
      end
      default: ;
    endcase
  end

  rfs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  rfs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .op_i    (sq_op),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: begin
        if (start_i) begin
          state_d = (in_box && n_calc >= IdxW'(2)) ? SRdA : SDone;
        end
      end
      SRdA:  state_d = SLdA;
      SLdA:  state_d = SRdB;
      SRdB:  state_d = SLdB;
      SLdB:  state_d = SL2A;
      SL2A:  state_d = SL2B;
      SL2B:  state_d = SL2C;
      SL2C:  state_d = SDtA;
      SDtA:  state_d = (len2_q == 52'd0) ? SNext : SDtB;
      SDtB:  state_d = STSel;
      STSel: state_d = t_mid ? STDiv : SDxA;
      STDiv: state_d = div_done ? SDxA : STDiv;
      SDxA:  state_d = SDxB;
      SDxB:  state_d = SDzB;
      SDzB:  state_d = SDdA;
      SDdA:  state_d = SDdB;
      SDdB:  state_d = SDdC;
      SDdC:  state_d = SDSq;
      SDSq:  state_d = sq_done ? SHA : SDSq;
      SHA:   state_d = SHB;
      SHB:   state_d = SHC;
      SHC:   state_d = SHChk;
      SHChk: state_d = seg_ok ? SLDiv : SNext;
      SLDiv: state_d = div_done ? SLCmp : SLDiv;
      SLCmp: state_d = seg_better ? SLSq : SNext;
      SLSq:  state_d = sq_done ? SUxS : SLSq;
      SUxS:  state_d = SUxW;
      SUxW:  state_d = div_done ? SUzS : SUxW;
      SUzS:  state_d = SUzW;
      SUzW:  state_d = div_done ? SPA : SUzW;
      SPA:   state_d = SPB;
      SPB:   state_d = SPC;
      SPC:   state_d = SPD;
      SPD:   state_d = SFxA;
      SFxA:  state_d = SFxB;
      SFxB:  state_d = SFxC;
      SFxC:  state_d = SFzB;
      SFzB:  state_d = SFzC;
      SFzC:  state_d = SSA;
      SSA:   state_d = SSB;
      SSB:   state_d = SSC;
      SSC:   state_d = SNext;
      SNext: state_d = ((idx_q + IdxW'(2)) < n_q) ? SRdB : SDone;
      SDone: state_d = out_free_i ? SIdle : SDone;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == SLdA) begin
        idx_q <= '0;
      end else if (state_q == SNext) begin
        idx_q <= idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    unique case (state_q)
      SIdle: begin
        if (start_i) begin
          px_q        <= px_i;
          pz_q        <= pz_i;
          n_q         <= n_calc;
          best_lat_q  <= OneQ16;
          best_w_q    <= '0;
          best_fx_q   <= '0;
          best_fz_q   <= '0;
          best_surf_q <= '0;
        end
      end
      SLdA: a_q <= rd_data_i;
      SLdB: begin
        b_q   <= rd_data_i;
        abx_q <= 25'(rd_data_i.x) - 25'(a_q.x);
        abz_q <= 25'(rd_data_i.z) - 25'(a_q.z);
        qx_q  <= 25'(px_q) - 25'(a_q.x);
        qz_q  <= 25'(pz_q) - 25'(a_q.z);
      end
      SL2B:  len2_q <= prod_q[51:0];
      SL2C:  len2_q <= len2_q + prod_q[51:0];
      SDtA:  dot_q  <= prod_q[51:0];
      SDtB:  dot_q  <= dot_q + prod_q[51:0];
      STSel: t_q    <= (dot_q > 52'sd0) ? OneQ16 : 17'd0;
      STDiv: if (div_done) t_q <= div_quo;
      SDxB:  dx_q   <= dx_full[43:16];
      SDzB:  dz_q   <= dz_full[43:16];
      SDdB:  sq_acc_q <= prod_q[55:0];
      SDSq:  if (sq_done) dist_q <= sq_root;
      SHB:   part_q <= prod_q;
      SHC:   half_q <= half_full[39:16];
      SHChk: if (dist_q == {4'd0, half_q}) lat_q <= OneQ16;
      SLDiv: if (div_done) lat_q <= div_quo;
      SLSq:  if (sq_done) len_q <= sq_root;
      SUxW:  if (div_done) ux_q <= abx_q[24] ? -$signed({1'b0, div_quo})
                                             : $signed({1'b0, div_quo});
      SUzW:  if (div_done) uz_q <= abz_q[24] ? -$signed({1'b0, div_quo})
                                             : $signed({1'b0, div_quo});
      SPB:   lat2_q <= lat2_full[32:16];
      SPD:   prof_q <= ProfBase + {1'b0, prof_full[31:16]};
      SFxC:  fx_q   <= flow_c;
      SFzC:  fz_q   <= flow_c;
      SSB:   part_q <= prod_q;
      SSC: begin
        best_lat_q  <= lat_q;
        best_w_q    <= OneQ16 - lat_q;
        best_fx_q   <= fx_q;
        best_fz_q   <= fz_q;
        best_surf_q <= surf_full[39:16];
      end
      SNext: a_q <= b_q;
      default: ;
    endcase
  end

  assign idle_o      = (state_q == SIdle);
  assign res_valid_o = (state_q == SDone) && out_free_i;
  assign rd_en_o     = (state_q == SRdA) || (state_q == SRdB);
  assign rd_addr_o   = (state_q == SRdA) ? '0 : NodeAw'(idx_q + IdxW'(1));

  assign res_o.flow_x      = best_fx_q;
  assign res_o.flow_z      = best_fz_q;
  assign res_o.weight      = best_w_q;
  assign res_o.surface_out = best_surf_q;

endmodule
